// File: hdl/wpem_pkg.sv
// ----------------------------------------------------------------------------
// wpem_pkg
// shared types, constants and byte classification helpers for the
// bold-prefix markup block
// ----------------------------------------------------------------------------
package wpem_pkg;

    // default word buffer depth in bytes
    localparam int WORD_BYTES_MAX_DEF = 48;

    // emphasis mode codes
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_SUBTLE = 2'd2;

    // tag characters
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
        logic       word_overlong;
    } t_out_word;

    // space, tab, line feed, vertical tab, form feed, return
    function automatic logic is_space_byte(input logic [7:0] b);
        return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
    endfunction

    // trailing punctuation set
    function automatic logic is_punct_byte(input logic [7:0] b);
        return b inside {8'h2E, 8'h2C, 8'h21, 8'h3F, 8'h3B, 8'h3A,
                         8'h22, 8'h27, 8'h29, 8'h5D, 8'h7D};
    endfunction

    // utf-8 sequence length from a lead byte, invalid leads count as one
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if ((b & 8'hE0) == 8'hC0) begin
            len = 3'd2;
        end else if ((b & 8'hF0) == 8'hE0) begin
            len = 3'd3;
        end else if ((b & 8'hF8) == 8'hF0) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    // number of bold characters; third taken as multiply by 43/128
    function automatic logic [7:0] prefix_chars(input logic [7:0] len,
                                                input logic [1:0] mode);
        logic [13:0] prod;
        logic [7:0]  n;
        prod = (14'(len) + 14'd2) * 14'd43;
        n    = 8'd0;
        if (len == 8'd0) begin
            n = 8'd0;
        end else if (mode == MODE_NORMAL) begin
            n = (len <= 8'd2) ? len : 8'((9'(len) + 9'd1) >> 1);
        end else if (mode == MODE_SUBTLE) begin
            n = (len <= 8'd2) ? 8'd1 : {1'b0, prod[13:7]};
        end
        return n;
    endfunction

    function automatic logic [7:0] open_tag_byte(input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0:    c = CH_LT;
            2'd1:    c = CH_B;
            default: c = CH_GT;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] close_tag_byte(input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0:    c = CH_LT;
            2'd1:    c = CH_SLASH;
            2'd2:    c = CH_B;
            default: c = CH_GT;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/word_prefix_emphasis_markup.sv
// ----------------------------------------------------------------------------
// word_prefix_emphasis_markup
// bolds the leading characters of each word of a utf-8 byte stream
// ----------------------------------------------------------------------------
// input: one text byte per word (i_in_word) with an end of text flag, taken
//   when i_in_valid is high and o_in_stall is low
// output: one marked-up byte per word (o_out_word), taken when o_out_valid
//   is high and i_out_stall is low; run_last marks the last byte caused by
//   an input word, text_done the last byte of the text
// config: i_cfg_wr_en / i_cfg_wr_data write the emphasis mode while idle
// timing: a word's output leaves one byte per cycle while the output is not
//   stalled, word bytes from the single read port of the word buffer, with
//   a pause before a close tag that has word bytes after it; a byte that is
//   only buffered produces no output
// reset: buffer empty, mode normal, output register empty; only the fill
//   count is cleared, not the buffer contents
// stall: the output register holds its word, the flush pauses and the input
//   stays stalled until the flush is done
// ----------------------------------------------------------------------------
module word_prefix_emphasis_markup #(
    parameter int WORD_BYTES_MAX = wpem_pkg::WORD_BYTES_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wpem_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wpem_pkg::t_out_word o_out_word
);
    import wpem_pkg::*;

    // address, count and walk position widths
    localparam int AW = (WORD_BYTES_MAX > 1) ? $clog2(WORD_BYTES_MAX) : 1;
    localparam int CW = $clog2(WORD_BYTES_MAX + 1);
    localparam int WW = $clog2(WORD_BYTES_MAX + 4);
    localparam logic [CW-1:0] DEPTH = CW'(WORD_BYTES_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN,
        S_BODY,
        S_CLOSE,
        S_TAIL
    } t_state;

    // word buffer
    logic [7:0]    r_mem [WORD_BYTES_MAX];
    logic [7:0]    r_mem_q;
    logic          r_fwd_hit;
    logic [7:0]    r_fwd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] mem_ra;
    logic [7:0]    rd_byte;

    // word tracking state
    logic [1:0]    r_mode, n_mode;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_core, n_core;
    logic [CW-1:0] r_chars_core, n_chars_core;
    logic [WW-1:0] r_walk, n_walk;
    logic [CW-1:0] r_starts, n_starts;
    logic          r_overlong, n_overlong;

    // flush sequencer
    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [1:0]    r_tag, n_tag;
    logic [WW-1:0] r_fnext, n_fnext;
    logic [CW-1:0] r_seen, n_seen;
    logic [CW-1:0] r_n, n_n;
    logic          r_marked, n_marked;
    logic          r_tag_done, n_tag_done;
    logic          r_raw_flag, n_raw_flag;
    logic          r_has_tail, n_has_tail;
    logic [7:0]    r_tail_byte, n_tail_byte;
    logic          r_tail_flag, n_tail_flag;
    logic          r_eot, n_eot;

    // output register
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out, n_out;

    // accept-time decode
    logic          in_accept;
    logic          emit_ok;
    logic          marking;
    logic          do_flush;
    logic          at_tag;
    logic          body_end;
    logic          last;
    logic [CW-1:0] idx_inc;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign emit_ok     = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign rd_byte     = r_fwd_hit ? r_fwd_data : r_mem_q;
    assign mem_ra      = (n_idx < DEPTH) ? n_idx[AW-1:0] : '0;
    assign idx_inc     = r_idx + CW'(1);

    // buffer: one write, one registered read, write forwarded on a match
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q    <= r_mem[mem_ra];
        r_fwd_hit  <= mem_we && (mem_wa == mem_ra);
        r_fwd_data <= mem_wd;
    end

    always_comb begin
        n_mode       = i_cfg_wr_en ? i_cfg_wr_data : r_mode;
        n_count      = r_count;
        n_core       = r_core;
        n_chars_core = r_chars_core;
        n_walk       = r_walk;
        n_starts     = r_starts;
        n_overlong   = r_overlong;
        n_state      = r_state;
        n_idx        = r_idx;
        n_tag        = r_tag;
        n_fnext      = r_fnext;
        n_seen       = r_seen;
        n_n          = r_n;
        n_marked     = r_marked;
        n_tag_done   = r_tag_done;
        n_raw_flag   = r_raw_flag;
        n_has_tail   = r_has_tail;
        n_tail_byte  = r_tail_byte;
        n_tail_flag  = r_tail_flag;
        n_eot        = r_eot;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        mem_we       = 1'b0;
        mem_wa       = r_count[AW-1:0];
        mem_wd       = i_in_word.in_byte;
        marking      = (r_mode == MODE_NORMAL) || (r_mode == MODE_SUBTLE);
        do_flush     = 1'b0;
        at_tag       = 1'b0;
        body_end     = 1'b0;
        last         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_marked    = 1'b0;
                    n_raw_flag  = 1'b0;
                    n_has_tail  = 1'b0;
                    n_tail_flag = 1'b0;
                    if (!marking) begin
                        // off mode: dump the buffer raw, then the byte
                        do_flush   = 1'b1;
                        n_has_tail = 1'b1;
                        n_overlong = 1'b0;
                    end else if (is_space_byte(i_in_word.in_byte)) begin
                        do_flush   = 1'b1;
                        n_marked   = 1'b1;
                        n_has_tail = 1'b1;
                        n_overlong = 1'b0;
                    end else if (r_overlong) begin
                        n_has_tail  = 1'b1;
                        n_tail_flag = 1'b1;
                        n_overlong  = !i_in_word.end_of_text;
                    end else if (r_count < DEPTH) begin
                        // buffer the byte and track lead bytes and the core
                        mem_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        if (WW'(r_count) == r_walk) begin
                            n_starts = r_starts + CW'(1);
                            n_walk   = WW'(r_count) + WW'(lead_len(i_in_word.in_byte));
                        end
                        if (!is_punct_byte(i_in_word.in_byte)) begin
                            n_core       = r_count + CW'(1);
                            n_chars_core = n_starts;
                        end
                        do_flush = i_in_word.end_of_text;
                        n_marked = 1'b1;
                    end else begin
                        // buffer full: dump flagged and pass the rest
                        do_flush    = 1'b1;
                        n_raw_flag  = 1'b1;
                        n_has_tail  = 1'b1;
                        n_tail_flag = 1'b1;
                        n_overlong  = !i_in_word.end_of_text;
                    end

                    n_n = CW'(prefix_chars(8'(n_chars_core), r_mode));
                    if (n_marked && (n_n == '0)) begin
                        n_marked = 1'b0;
                    end

                    n_idx       = '0;
                    n_fnext     = '0;
                    n_seen      = '0;
                    n_tag       = '0;
                    n_tag_done  = 1'b0;
                    n_tail_byte = i_in_word.in_byte;
                    n_eot       = i_in_word.end_of_text;

                    if (do_flush && (n_count != '0)) begin
                        n_state = n_marked ? S_OPEN : S_BODY;
                    end else if (n_has_tail) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_OPEN: begin
                if (emit_ok) begin
                    n_out_valid           = 1'b1;
                    n_out.out_byte        = open_tag_byte(r_tag);
                    n_out.word_overlong   = 1'b0;
                    n_out.run_last        = 1'b0;
                    n_out.text_done       = 1'b0;
                    if (r_tag == 2'd2) begin
                        n_tag   = '0;
                        n_state = S_BODY;
                    end else begin
                        n_tag = r_tag + 2'd1;
                    end
                end
            end

            S_BODY: begin
                // close tag goes in front of this byte once n chars are out
                // or the trailing punctuation starts
                at_tag = r_marked && !r_tag_done &&
                         (((WW'(r_idx) == r_fnext) && (r_seen == r_n)) ||
                          (r_idx == r_core));
                if (at_tag) begin
                    n_state = S_CLOSE;
                end else if (emit_ok) begin
                    body_end            = (idx_inc == r_count);
                    last                = body_end && !(r_marked && !r_tag_done) &&
                                          !r_has_tail;
                    n_out_valid         = 1'b1;
                    n_out.out_byte      = rd_byte;
                    n_out.word_overlong = r_raw_flag;
                    n_out.run_last      = last;
                    n_out.text_done     = last && r_eot;
                    n_idx               = idx_inc;
                    if (WW'(r_idx) == r_fnext) begin
                        n_seen  = r_seen + CW'(1);
                        n_fnext = WW'(r_idx) + WW'(lead_len(rd_byte));
                    end
                    if (body_end) begin
                        if (r_marked && !r_tag_done) begin
                            n_state = S_CLOSE;
                        end else begin
                            n_count      = '0;
                            n_core       = '0;
                            n_chars_core = '0;
                            n_walk       = '0;
                            n_starts     = '0;
                            n_state      = r_has_tail ? S_TAIL : S_IDLE;
                        end
                    end
                end
            end

            S_CLOSE: begin
                if (emit_ok) begin
                    body_end            = (r_tag == 2'd3) && (r_idx == r_count);
                    last                = body_end && !r_has_tail;
                    n_out_valid         = 1'b1;
                    n_out.out_byte      = close_tag_byte(r_tag);
                    n_out.word_overlong = 1'b0;
                    n_out.run_last      = last;
                    n_out.text_done     = last && r_eot;
                    if (r_tag == 2'd3) begin
                        n_tag      = '0;
                        n_tag_done = 1'b1;
                        if (body_end) begin
                            n_count      = '0;
                            n_core       = '0;
                            n_chars_core = '0;
                            n_walk       = '0;
                            n_starts     = '0;
                            n_state      = r_has_tail ? S_TAIL : S_IDLE;
                        end else begin
                            n_state = S_BODY;
                        end
                    end else begin
                        n_tag = r_tag + 2'd1;
                    end
                end
            end

            S_TAIL: begin
                if (emit_ok) begin
                    n_out_valid         = 1'b1;
                    n_out.out_byte      = r_tail_byte;
                    n_out.word_overlong = r_tail_flag;
                    n_out.run_last      = 1'b1;
                    n_out.text_done     = r_eot;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_count      <= '0;
            r_core       <= '0;
            r_chars_core <= '0;
            r_walk       <= '0;
            r_starts     <= '0;
            r_overlong   <= 1'b0;
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_count      <= n_count;
            r_core       <= n_core;
            r_chars_core <= n_chars_core;
            r_walk       <= n_walk;
            r_starts     <= n_starts;
            r_overlong   <= n_overlong;
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_tag       <= n_tag;
        r_fnext     <= n_fnext;
        r_seen      <= n_seen;
        r_n         <= n_n;
        r_marked    <= n_marked;
        r_tag_done  <= n_tag_done;
        r_raw_flag  <= n_raw_flag;
        r_has_tail  <= n_has_tail;
        r_tail_byte <= n_tail_byte;
        r_tail_flag <= n_tail_flag;
        r_eot       <= n_eot;
        r_out       <= n_out;
    end

endmodule

// File: dv/word_prefix_emphasis_markup_checker.sv
// ----------------------------------------------------------------------------
// word_prefix_emphasis_markup_checker
// watches both channels and the mode register of the markup block, predicts
// the marked-up byte stream from every accepted input word and compares it
// with every accepted output word, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module word_prefix_emphasis_markup_checker #(
    parameter int WORD_BYTES_MAX = wpem_pkg::WORD_BYTES_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_wr_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  wpem_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  wpem_pkg::t_out_word i_out_word,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_flagged
);

    import wpem_pkg::*;

    // predictor state
    logic [7:0]  held_bytes [WORD_BYTES_MAX];
    int unsigned held_count;
    int unsigned core_len;
    bit          passing_long;
    logic [1:0]  cur_mode;
    int          step_emitted;

    // expected output bytes, oldest first
    t_out_word   markup_q [$];

    int fails;
    int checked;
    int flagged;

    initial begin
        held_count   = 0;
        core_len     = 0;
        passing_long = 1'b0;
        cur_mode     = MODE_NORMAL;
        fails        = 0;
        checked      = 0;
        flagged      = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_flagged    = 0;
    end

    function automatic bit is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit is_trail_punct(input logic [7:0] b);
        case (b)
            8'h2E, 8'h2C, 8'h21, 8'h3F, 8'h3B, 8'h3A,
            8'h22, 8'h27, 8'h29, 8'h5D, 8'h7D: return 1'b1;
            default:                            return 1'b0;
        endcase
    endfunction

    // bytes taken by the character that starts with this byte
    function automatic int unsigned seq_len(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 1;
        endcase
    endfunction

    function automatic int unsigned bold_chars(input int unsigned n_chars,
                                               input logic [1:0] mode);
        if (n_chars == 0) begin
            return 0;
        end
        case (mode)
            MODE_NORMAL: return (n_chars <= 2) ? n_chars : (n_chars + 1) / 2;
            MODE_SUBTLE: return (n_chars <= 2) ? 1 : (n_chars + 2) / 3;
            default:     return 0;
        endcase
    endfunction

    task automatic emit(input logic [7:0] b, input logic flag);
        t_out_word w;
        w.out_byte      = b;
        w.run_last      = 1'b0;
        w.text_done     = 1'b0;
        w.word_overlong = flag;
        markup_q = {markup_q, w};
        step_emitted++;
    endtask

    task automatic flush_plain(input logic flag);
        for (int unsigned i = 0; i < held_count; i++) begin
            emit(held_bytes[i], flag);
        end
        held_count = 0;
        core_len   = 0;
    endtask

    task automatic flush_marked();
        int unsigned n_chars;
        int unsigned pos;
        int unsigned n_bold;
        int unsigned cut;
        n_chars = 0;
        pos     = 0;
        while (pos < core_len) begin
            pos += seq_len(held_bytes[pos]);
            n_chars++;
        end
        n_bold = bold_chars(n_chars, cur_mode);
        if (n_bold == 0) begin
            flush_plain(1'b0);
        end else begin
            cut     = 0;
            n_chars = 0;
            while (cut < core_len && n_chars < n_bold) begin
                cut += seq_len(held_bytes[cut]);
                n_chars++;
            end
            // a multi-byte prefix may run past the core; clip it
            if (cut > core_len) begin
                cut = core_len;
            end
            emit(CH_LT, 1'b0);
            emit(CH_B, 1'b0);
            emit(CH_GT, 1'b0);
            for (int unsigned i = 0; i < cut; i++) begin
                emit(held_bytes[i], 1'b0);
            end
            emit(CH_LT, 1'b0);
            emit(CH_SLASH, 1'b0);
            emit(CH_B, 1'b0);
            emit(CH_GT, 1'b0);
            for (int unsigned i = cut; i < held_count; i++) begin
                emit(held_bytes[i], 1'b0);
            end
            held_count = 0;
            core_len   = 0;
        end
    endtask

    task automatic predict_markup(input t_in_word w);
        bit        marking;
        t_out_word tail;
        step_emitted = 0;
        marking      = (cur_mode == MODE_NORMAL) || (cur_mode == MODE_SUBTLE);
        if (!marking) begin
            flush_plain(1'b0);
            passing_long = 1'b0;
            emit(w.in_byte, 1'b0);
        end else if (is_blank(w.in_byte)) begin
            flush_marked();
            passing_long = 1'b0;
            emit(w.in_byte, 1'b0);
        end else if (passing_long) begin
            emit(w.in_byte, 1'b1);
        end else if (held_count < WORD_BYTES_MAX) begin
            held_bytes[held_count] = w.in_byte;
            held_count++;
            if (!is_trail_punct(w.in_byte)) begin
                core_len = held_count;
            end
        end else begin
            flush_plain(1'b1);
            emit(w.in_byte, 1'b1);
            passing_long = 1'b1;
        end
        if (w.end_of_text) begin
            if (marking) begin
                flush_marked();
            end else begin
                flush_plain(1'b0);
            end
            passing_long = 1'b0;
        end
        if (step_emitted > 0) begin
            tail           = markup_q[markup_q.size() - 1];
            tail.run_last  = 1'b1;
            tail.text_done = w.end_of_text;
            markup_q[markup_q.size() - 1] = tail;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fails++;
        end
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (markup_q.size() == 0) begin
            $error("output word %h arrived with nothing expected", got);
            fails++;
        end else begin
            want = markup_q.pop_front();
            checked++;
            if (got.word_overlong === 1'b1) begin
                flagged++;
            end
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("run_last", 8'(want.run_last), 8'(got.run_last));
            check_field("text_done", 8'(want.text_done), 8'(got.text_done));
            check_field("word_overlong", 8'(want.word_overlong),
                        8'(got.word_overlong));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count   = 0;
            core_len     = 0;
            passing_long = 1'b0;
            cur_mode     = MODE_NORMAL;
            markup_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_word);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_markup(i_in_word);
            end
            if (i_cfg_wr_en) begin
                cur_mode = i_cfg_wr_data;
            end
        end
        o_fail_count <= fails;
        o_pending    <= markup_q.size();
        o_checked    <= checked;
        o_flagged    <= flagged;
    end

endmodule

// File: dv/word_prefix_emphasis_markup_tb.sv
// ----------------------------------------------------------------------------
// word_prefix_emphasis_markup_tb
// drives text through the markup block under every emphasis mode and lets
// the checker compare the output stream byte by byte
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module word_prefix_emphasis_markup_tb;

    import wpem_pkg::*;

    localparam int WORD_BYTES_MAX = WORD_BYTES_MAX_DEF;

    // mode code with no meaning of its own, the block treats it as off
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // idle cycles after the last expected byte: covers a buffered byte that
    // is still being absorbed and gives margin over the output latency
    localparam int SETTLE_CYCLES = 8;

    // cycles with no word moving on either channel before giving up
    localparam int WATCHDOG_LIMIT = 2000;

    // random phase length in input words
    localparam int PHASE_WORDS = 45;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = MODE_NORMAL;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_word   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_word  out_word;

    int chk_failures;
    int chk_pending;
    int chk_checked;
    int chk_flagged;

    // stimulus bookkeeping
    logic [7:0] chunk_q [$];
    int         burst_left = 0;
    int         words_sent = 0;
    int         mode_writes = 0;

    // receiver stall pattern state
    int         stall_style = 0;
    int         style_left = 0;
    int         hold_left = 0;

    // watchdog
    int         quiet_cycles = 0;

    always #2 clk = ~clk;

    word_prefix_emphasis_markup #(
        .WORD_BYTES_MAX (WORD_BYTES_MAX)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_word     (in_word),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_word    (out_word)
    );

    word_prefix_emphasis_markup_checker #(
        .WORD_BYTES_MAX (WORD_BYTES_MAX)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_word     (in_word),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_word    (out_word),
        .o_fail_count  (chk_failures),
        .o_pending     (chk_pending),
        .o_checked     (chk_checked),
        .o_flagged     (chk_flagged)
    );

    // receiver stall: the style is redrawn now and then at random, so that
    // stalls land on every part of a flush
    //   0 never stall, 1 light random, 2 heavy random, 3 long on/off holds
    always @(negedge clk) begin
        if (style_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            style_left  <= $urandom_range(40, 200);
        end else begin
            style_left <= style_left - 1;
        end
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if (hold_left == 0) begin
                    out_stall <= ~out_stall;
                    hold_left <= $urandom_range(1, 12);
                end else begin
                    hold_left <= hold_left - 1;
                end
            end
        endcase
    end

    // watchdog: a run that stops moving words is a failure
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("word_prefix_emphasis_markup test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input word; the sender works in bursts with idle gaps between
    // them, and a long burst now and then gives stretches with no idling
    task automatic send_byte(input logic [7:0] b, input logic eot);
        @(negedge clk);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        in_word  <= '{in_byte: b, end_of_text: eot};
        in_valid <= 1'b1;
        // payload holds until the block takes it
        do begin
            @(posedge clk);
        end while (in_stall);
        words_sent++;
    endtask

    // send the chunk queue, optionally ending the text on its last byte
    task automatic send_chunk(input bit eot_at_end);
        foreach (chunk_q[i]) begin
            send_byte(chunk_q[i], eot_at_end && (i == chunk_q.size() - 1));
        end
    endtask

    // stop sending and wait until every expected byte has come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (chk_pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mode changes only while the block is idle
    task automatic enter_mode(input logic [1:0] mode);
        drain();
        cfg_wr_data <= mode;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mode_writes++;
    endtask

    // append one byte to the chunk being built
    task automatic add_byte(input logic [7:0] b);
        chunk_q = {chunk_q, b};
    endtask

    function automatic logic [7:0] rand_punct();
        case ($urandom_range(0, 10))
            0:       return 8'h2E;   // .
            1:       return 8'h2C;   // ,
            2:       return 8'h21;   // !
            3:       return 8'h3F;   // ?
            4:       return 8'h3B;   // ;
            5:       return 8'h3A;   // :
            6:       return 8'h22;   // double quote
            7:       return 8'h27;   // single quote
            8:       return 8'h29;   // )
            9:       return 8'h5D;   // ]
            default: return 8'h7D;   // }
        endcase
    endfunction

    // one character of a word: mostly letters and well-formed utf-8, with
    // truncated sequences, stray continuation bytes, invalid leads, control
    // bytes and inner punctuation mixed in
    task automatic add_char();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            add_byte(8'($urandom_range(8'h61, 8'h7A)));
        end else if (pick < 65) begin
            add_byte(8'($urandom_range(8'hC0, 8'hDF)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 72) begin
            add_byte(8'($urandom_range(8'hE0, 8'hEF)));
            repeat (2) add_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 78) begin
            add_byte(8'($urandom_range(8'hF0, 8'hF7)));
            repeat (3) add_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 84) begin
            // lead byte without its continuation bytes
            add_byte(8'($urandom_range(8'hC0, 8'hF7)));
        end else if (pick < 88) begin
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 91) begin
            add_byte(8'($urandom_range(8'hF8, 8'hFF)));
        end else if (pick < 95) begin
            // control bytes that are not whitespace, and delete
            v = $urandom_range(0, 23);
            add_byte((v < 9) ? 8'(v) : ((v < 23) ? 8'(v + 5) : 8'h7F));
        end else begin
            add_byte(rand_punct());
        end
    endtask

    // random text under one mode; phases do not always end on whitespace,
    // so a word may still be buffered when the mode changes
    task automatic run_phase(input logic [1:0] mode);
        int sent;
        int pick;
        int want_len;
        enter_mode(mode);
        sent = 0;
        while (sent < PHASE_WORDS) begin
            chunk_q.delete();
            pick = $urandom_range(0, 99);
            if (pick < 64) begin
                // ordinary word with optional trailing punctuation
                repeat ($urandom_range(1, 8)) add_char();
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 3)) add_byte(rand_punct());
                end
            end else if (pick < 72) begin
                // punctuation only: empty core, sent without tags
                repeat ($urandom_range(1, 3)) add_byte(rand_punct());
            end else if (pick < 80) begin
                // near or past the buffer size
                want_len = ($urandom_range(0, 1) == 0)
                         ? $urandom_range(WORD_BYTES_MAX - 3, WORD_BYTES_MAX)
                         : $urandom_range(WORD_BYTES_MAX + 1, WORD_BYTES_MAX + 16);
                while (chunk_q.size() < want_len) begin
                    add_char();
                end
                while (chunk_q.size() > want_len) begin
                    void'(chunk_q.pop_back());
                end
            end else begin
                // raw noise, any byte value
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) != 0) begin
                add_byte(($urandom_range(0, 1) == 0)
                         ? 8'h20 : 8'($urandom_range(8'h09, 8'h0D)));
            end
            send_chunk($urandom_range(0, 11) == 0);
            sent += chunk_q.size();
        end
    endtask

    initial begin
        // hold synchronous reset, then release it
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // normal mode: one-letter word fully bold, utf-8 prefix, trailing
        // punctuation, punctuation-only word, four-byte character, the
        // byte extremes, a stray continuation byte, end of text
        enter_mode(MODE_NORMAL);
        chunk_q = '{8'h61, 8'h20, 8'h62, 8'h63, 8'h64, 8'hC3, 8'hA9, 8'h21,
                    8'h3F, 8'h09, 8'h2E, 8'h2E, 8'h0A, 8'hF0, 8'h9F, 8'h98,
                    8'h80, 8'h00, 8'hFF, 8'h80, 8'h3B};
        send_chunk(1'b1);

        // subtle mode: short word gets one bold character, five letters two
        enter_mode(MODE_SUBTLE);
        chunk_q = '{8'h61, 8'h20, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67};
        send_chunk(1'b1);

        // random text through every setting, off and the unused code too
        run_phase(MODE_SUBTLE);
        run_phase(MODE_OFF);
        run_phase(MODE_NORMAL);
        run_phase(MODE_UNUSED);
        run_phase(MODE_SUBTLE);
        run_phase(MODE_NORMAL);

        drain();

        $display("sent %0d text bytes over %0d mode settings", words_sent, mode_writes);
        $display("checked %0d output bytes, %0d of them from overlong words",
                 chk_checked, chk_flagged);
        if (chk_failures == 0) begin
            $display("word_prefix_emphasis_markup test passed");
        end else begin
            $display("word_prefix_emphasis_markup test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/wpem_pkg.sv
hdl/word_prefix_emphasis_markup.sv
dv/word_prefix_emphasis_markup_checker.sv
dv/word_prefix_emphasis_markup_tb.sv
